// ----- design/grgf_pkg.sv -----
// Shared constants, fill codes and the cell control bundle of the grid row gap filler.
`default_nettype none

package grgf_pkg;

    // Default sizes handed to the top level parameters
    localparam int SEARCH_REACH_DEF = 50;
    localparam int VALUE_BITS_DEF   = 16;

    // Distances examined per scan cycle
    localparam int SCAN_STEP = 8;

    // Fill codes carried on the result channel
    localparam logic [1:0] CODE_ORIGINAL = 2'd0;
    localparam logic [1:0] CODE_PREVIOUS = 2'd1;
    localparam logic [1:0] CODE_NEIGHBOR = 2'd2;

    // Commands broadcast from the sequencer to every cell
    typedef struct packed {
        logic append;
        logic shift_pend;
        logic shift_left;
        logic clear_left;
        logic load_scan;
        logic shift_scan;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- design/grgf_cell.sv -----
// One search distance of the row window: a held point, a left history entry and a scan slot.
`default_nettype none

module grgf_cell
    import grgf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int INDEX      = 1,
    parameter int COUNT_BITS = 6
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  cell_ctrl_t                    ctrl,
    input  wire        [COUNT_BITS-1:0]   pend_count,
    input  wire signed [VALUE_BITS-1:0]   new_today,
    input  wire signed [VALUE_BITS-1:0]   new_prev,
    input  wire signed [VALUE_BITS-1:0]   nb_today,
    input  wire signed [VALUE_BITS-1:0]   nb_prev,
    input  wire                           nb_valid,
    output logic signed [VALUE_BITS-1:0]  pend_today,
    output logic signed [VALUE_BITS-1:0]  pend_prev,
    output logic                          pend_valid,
    input  wire signed [VALUE_BITS-1:0]   nb_left,
    output logic signed [VALUE_BITS-1:0]  left_val,
    input  wire                           nb_scan_hit,
    input  wire signed [VALUE_BITS-1:0]   nb_scan_val,
    output logic                          scan_hit,
    output logic signed [VALUE_BITS-1:0]  scan_val
);

    logic signed [VALUE_BITS-1:0] today_reg;
    logic signed [VALUE_BITS-1:0] prev_reg;
    logic                         valid_reg;
    logic signed [VALUE_BITS-1:0] left_reg;
    logic                         hit_reg;
    logic signed [VALUE_BITS-1:0] sval_reg;

    logic append_here;
    logic left_pos;
    logic right_pos;

    assign append_here = ctrl.append && (pend_count == COUNT_BITS'(INDEX));
    assign left_pos    = !left_reg[VALUE_BITS-1] && (|left_reg);
    assign right_pos   = valid_reg && !today_reg[VALUE_BITS-1] && (|today_reg);

    // Advance held points toward the head, or take a new item at the fill position
    always_ff @(posedge aclk) begin
        if (ctrl.shift_pend) begin
            today_reg <= nb_today;
            prev_reg  <= nb_prev;
        end else if (append_here) begin
            today_reg <= new_today;
            prev_reg  <= new_prev;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.shift_pend) begin
            valid_reg <= nb_valid;
        end else if (append_here) begin
            valid_reg <= 1'b1;
        end
    end

    // Left history: push emitted values outward, drop at row end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
        end else if (ctrl.clear_left) begin
            left_reg <= '0;
        end else if (ctrl.shift_left) begin
            left_reg <= nb_left;
        end
    end

    // Scan slot: left side wins over right side at the same distance
    always_ff @(posedge aclk) begin
        if (ctrl.load_scan) begin
            hit_reg  <= left_pos || right_pos;
            sval_reg <= left_pos ? left_reg : today_reg;
        end else if (ctrl.shift_scan) begin
            hit_reg  <= nb_scan_hit;
            sval_reg <= nb_scan_val;
        end
    end

    assign pend_today = today_reg;
    assign pend_prev  = prev_reg;
    assign pend_valid = valid_reg;
    assign left_val   = left_reg;
    assign scan_hit   = hit_reg;
    assign scan_val   = sval_reg;

endmodule

`default_nettype wire

// ----- design/grgf_ctrl.sv -----
// Sequencer: head point, fill decision, scan window pick, result register and config register.
`default_nettype none

module grgf_ctrl
    import grgf_pkg::*;
#(
    parameter int VALUE_BITS   = VALUE_BITS_DEF,
    parameter int SEARCH_REACH = SEARCH_REACH_DEF,
    parameter int COUNT_BITS   = 6
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    // input items
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire signed [VALUE_BITS-1:0]   in_today,
    input  wire signed [VALUE_BITS-1:0]   in_prev,
    input  wire                           in_row_end,
    // configuration
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire                           cfg_data,
    // result items
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic       [VALUE_BITS-2:0]   out_value,
    output logic       [1:0]              out_code,
    output logic                          out_miss,
    output logic                          out_last,
    // cell row
    output cell_ctrl_t                    ctrl,
    output logic       [COUNT_BITS-1:0]   pend_count,
    input  wire signed [VALUE_BITS-1:0]   next_today,
    input  wire signed [VALUE_BITS-1:0]   next_prev,
    output logic signed [VALUE_BITS-1:0]  emit_val,
    input  wire                           win_hit [SCAN_STEP],
    input  wire signed [VALUE_BITS-1:0]   win_val [SCAN_STEP]
);

    localparam int SCAN_PASSES = (SEARCH_REACH + SCAN_STEP - 1) / SCAN_STEP;
    localparam int PASS_BITS   = $clog2(SCAN_PASSES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                   state_reg,  state_next;
    logic [COUNT_BITS-1:0]        count_reg,  count_next;
    logic                         drain_reg,  drain_next;
    logic [PASS_BITS-1:0]         passes_reg, passes_next;
    logic                         fill_en_reg;
    logic signed [VALUE_BITS-1:0] head_today_reg;
    logic signed [VALUE_BITS-1:0] head_prev_reg;
    logic signed [VALUE_BITS-1:0] res_val_reg,  res_val_next;
    logic [1:0]                   res_code_reg, res_code_next;
    logic                         res_miss_reg, res_miss_next;
    logic                         m_valid_reg;
    logic [VALUE_BITS-2:0]        m_value_reg;
    logic [1:0]                   m_code_reg;
    logic                         m_miss_reg;
    logic                         m_last_reg;

    logic                         accept;
    logic                         out_free;
    logic                         commit;
    logic                         is_last;
    logic                         win_found;
    logic signed [VALUE_BITS-1:0] win_pick;
    logic                         res_pos;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || out_ready;
    assign commit   = (state_reg == S_OUT) && out_free;
    assign is_last  = drain_reg && (count_reg == COUNT_BITS'(1));
    assign res_pos  = !res_val_reg[VALUE_BITS-1] && (|res_val_reg);

    // Pick the nearest hit in the current scan window
    always_comb begin
        win_found = 1'b0;
        win_pick  = '0;
        for (int j = SCAN_STEP - 1; j >= 0; j--) begin
            if (win_hit[j]) begin
                win_found = 1'b1;
                win_pick  = win_val[j];
            end
        end
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        drain_next    = drain_reg;
        passes_next   = passes_reg;
        res_val_next  = res_val_reg;
        res_code_next = res_code_reg;
        res_miss_next = res_miss_reg;
        ctrl          = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    ctrl.append = 1'b1;
                    count_next  = count_reg + COUNT_BITS'(1);
                    drain_next  = in_row_end;
                    if (in_row_end || (count_reg == COUNT_BITS'(SEARCH_REACH))) begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                if (!fill_en_reg || (head_today_reg != '0)) begin
                    res_val_next  = head_today_reg;
                    res_code_next = CODE_ORIGINAL;
                    res_miss_next = 1'b0;
                    state_next    = S_OUT;
                end else if (head_prev_reg != '0) begin
                    res_val_next  = head_prev_reg;
                    res_code_next = CODE_PREVIOUS;
                    res_miss_next = 1'b1;
                    state_next    = S_OUT;
                end else begin
                    res_val_next   = '0;
                    res_code_next  = CODE_ORIGINAL;
                    res_miss_next  = 1'b1;
                    ctrl.load_scan = 1'b1;
                    passes_next    = PASS_BITS'(SCAN_PASSES);
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (win_found) begin
                    res_val_next  = win_pick;
                    res_code_next = CODE_NEIGHBOR;
                    state_next    = S_OUT;
                end else if (passes_reg == PASS_BITS'(1)) begin
                    state_next = S_OUT;
                end else begin
                    ctrl.shift_scan = 1'b1;
                    passes_next     = passes_reg - PASS_BITS'(1);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    ctrl.shift_pend = 1'b1;
                    ctrl.shift_left = !is_last;
                    ctrl.clear_left = is_last;
                    count_next      = count_reg - COUNT_BITS'(1);
                    if (is_last) begin
                        drain_next = 1'b0;
                        state_next = S_IDLE;
                    end else if (drain_reg) begin
                        state_next = S_EVAL;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            drain_reg  <= 1'b0;
            passes_reg <= '0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            drain_reg  <= drain_next;
            passes_reg <= passes_next;
        end
    end

    // Result under evaluation
    always_ff @(posedge aclk) begin
        res_val_reg  <= res_val_next;
        res_code_reg <= res_code_next;
        res_miss_reg <= res_miss_next;
    end

    // Head of the row window: oldest held point
    always_ff @(posedge aclk) begin
        if (ctrl.shift_pend) begin
            head_today_reg <= next_today;
            head_prev_reg  <= next_prev;
        end else if (accept && (count_reg == '0)) begin
            head_today_reg <= in_today;
            head_prev_reg  <= in_prev;
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_en_reg <= 1'b1;
        end else if (cfg_valid) begin
            fill_en_reg <= cfg_data;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (out_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_value_reg <= res_pos ? res_val_reg[VALUE_BITS-2:0] : '0;
            m_code_reg  <= res_code_reg;
            m_miss_reg  <= res_miss_reg;
            m_last_reg  <= is_last;
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = m_valid_reg;
    assign out_value  = m_value_reg;
    assign out_code   = m_code_reg;
    assign out_miss   = m_miss_reg;
    assign out_last   = m_last_reg;
    assign pend_count = count_reg;
    assign emit_val   = res_val_reg;

endmodule

`default_nettype wire

// ----- design/grid_row_gap_filler_unit.sv -----
// Top level of the grid row gap filler: sequencer and the row of distance cells.
`default_nettype none

// Fills missing (zero) grid points row by row. A point is held until SEARCH_REACH
// later points of its row have arrived or its row ends (tlast); then it is replaced
// by the previous day's value when that is nonzero, or else by the nearest positive
// value of the row within SEARCH_REACH places, left (already filled) before right.
// Items are handled one at a time. Each result is evaluated and then emitted,
// with a row search in between for a point that needs one: the search walks
// the cell row eight distances per cycle. A row end drains every held point
// back to back before the next item is taken. Emitting waits while the output
// register is full and not taken. fill_enable is written on the cfg channel;
// the user is to write it only while the block is idle, which the block itself
// does not enforce; it resets to 1.
module grid_row_gap_filler_unit
    import grgf_pkg::*;
#(
    parameter int SEARCH_REACH = SEARCH_REACH_DEF,
    parameter int VALUE_BITS   = VALUE_BITS_DEF
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    // today_value [VALUE_BITS-1:0], previous_value [2*VALUE_BITS-1:VALUE_BITS]
    input  wire [((2*VALUE_BITS+7)/8)*8-1:0]      s_tdata,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire                                   s_tlast,
    // filled_value [VALUE_BITS-2:0]
    output logic [((VALUE_BITS-1+7)/8)*8-1:0]     m_tdata,
    // fill_code [1:0], was_missing [2]
    output logic [2:0]                            m_tuser,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    output logic                                  m_tlast,
    // fill_enable
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire                                   cfg_data
);

    localparam int COUNT_BITS = $clog2(SEARCH_REACH + 2);
    localparam int OUT_BITS   = ((VALUE_BITS - 1 + 7) / 8) * 8;

    cell_ctrl_t                   ctrl;
    logic [COUNT_BITS-1:0]        pend_count;
    logic signed [VALUE_BITS-1:0] in_today;
    logic signed [VALUE_BITS-1:0] in_prev;
    logic signed [VALUE_BITS-1:0] emit_val;
    logic [VALUE_BITS-2:0]        out_value;
    logic [1:0]                   out_code;
    logic                         out_miss;

    logic signed [VALUE_BITS-1:0] c_today    [1:SEARCH_REACH];
    logic signed [VALUE_BITS-1:0] c_prev     [1:SEARCH_REACH];
    logic                         c_valid    [1:SEARCH_REACH];
    logic signed [VALUE_BITS-1:0] c_left     [1:SEARCH_REACH];
    logic                         c_hit      [1:SEARCH_REACH];
    logic signed [VALUE_BITS-1:0] c_sval     [1:SEARCH_REACH];
    logic                         win_hit    [SCAN_STEP];
    logic signed [VALUE_BITS-1:0] win_val    [SCAN_STEP];

    assign in_today = s_tdata[VALUE_BITS-1:0];
    assign in_prev  = s_tdata[2*VALUE_BITS-1:VALUE_BITS];

    grgf_ctrl #(
        .VALUE_BITS   (VALUE_BITS),
        .SEARCH_REACH (SEARCH_REACH),
        .COUNT_BITS   (COUNT_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_today   (in_today),
        .in_prev    (in_prev),
        .in_row_end (s_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (out_value),
        .out_code   (out_code),
        .out_miss   (out_miss),
        .out_last   (m_tlast),
        .ctrl       (ctrl),
        .pend_count (pend_count),
        .next_today (c_today[1]),
        .next_prev  (c_prev[1]),
        .emit_val   (emit_val),
        .win_hit    (win_hit),
        .win_val    (win_val)
    );

    // Row of cells, one per search distance
    for (genvar k = 1; k <= SEARCH_REACH; k++) begin : g_cell
        logic signed [VALUE_BITS-1:0] nb_today;
        logic signed [VALUE_BITS-1:0] nb_prev;
        logic                         nb_valid;
        logic signed [VALUE_BITS-1:0] nb_left;
        logic                         nb_hit;
        logic signed [VALUE_BITS-1:0] nb_sval;

        if (k < SEARCH_REACH) begin : g_right
            assign nb_today = c_today[k+1];
            assign nb_prev  = c_prev[k+1];
            assign nb_valid = c_valid[k+1];
        end else begin : g_end
            assign nb_today = '0;
            assign nb_prev  = '0;
            assign nb_valid = 1'b0;
        end

        if (k > 1) begin : g_left
            assign nb_left = c_left[k-1];
        end else begin : g_first
            assign nb_left = emit_val;
        end

        if (k + SCAN_STEP <= SEARCH_REACH) begin : g_scan
            assign nb_hit  = c_hit[k+SCAN_STEP];
            assign nb_sval = c_sval[k+SCAN_STEP];
        end else begin : g_scan_end
            assign nb_hit  = 1'b0;
            assign nb_sval = '0;
        end

        grgf_cell #(
            .VALUE_BITS (VALUE_BITS),
            .INDEX      (k),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .pend_count  (pend_count),
            .new_today   (in_today),
            .new_prev    (in_prev),
            .nb_today    (nb_today),
            .nb_prev     (nb_prev),
            .nb_valid    (nb_valid),
            .pend_today  (c_today[k]),
            .pend_prev   (c_prev[k]),
            .pend_valid  (c_valid[k]),
            .nb_left     (nb_left),
            .left_val    (c_left[k]),
            .nb_scan_hit (nb_hit),
            .nb_scan_val (nb_sval),
            .scan_hit    (c_hit[k]),
            .scan_val    (c_sval[k])
        );
    end

    // Scan window: the nearest SCAN_STEP distances
    for (genvar j = 0; j < SCAN_STEP; j++) begin : g_win
        if (j + 1 <= SEARCH_REACH) begin : g_tap
            assign win_hit[j] = c_hit[j+1];
            assign win_val[j] = c_sval[j+1];
        end else begin : g_none
            assign win_hit[j] = 1'b0;
            assign win_val[j] = '0;
        end
    end

    assign m_tdata = OUT_BITS'(out_value);
    assign m_tuser = {out_miss, out_code};

endmodule

`default_nettype wire

// ----- design/grgf_checker.sv -----
// Port-level checks of the grid row gap filler, bound to the top level.
`default_nettype none

module grgf_checker
    import grgf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input wire                                aclk,
    input wire                                aresetn,
    input wire                                s_tvalid,
    input wire                                s_tready,
    input wire                                s_tlast,
    input wire [((VALUE_BITS-1+7)/8)*8-1:0]   m_tdata,
    input wire [2:0]                          m_tuser,
    input wire                                m_tvalid,
    input wire                                m_tready,
    input wire                                m_tlast
);

    // A stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // A row end starts the drain, so the next item is not taken at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("item taken during row drain");

    // Fill codes stay within the defined set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[1:0] == CODE_ORIGINAL || m_tuser[1:0] == CODE_PREVIOUS
            || m_tuser[1:0] == CODE_NEIGHBOR)
        else $error("undefined fill code");

    // Any fill implies a missing point
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] != CODE_ORIGINAL |-> m_tuser[2])
        else $error("fill without missing mark");

    // A neighbor fill always carries a positive value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == CODE_NEIGHBOR |-> m_tdata != '0)
        else $error("neighbor fill with zero value");

endmodule

bind grid_row_gap_filler_unit grgf_checker #(.VALUE_BITS(VALUE_BITS)) u_grgf_checker (.*);

`default_nettype wire

// ----- verif/gap_fill_checker.sv -----
// Result checker for the grid row gap filler: predicts filled points and compares them.
module gap_fill_checker
    import grgf_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire [31:0]  s_tdata,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire         s_tlast,
    input  wire [15:0]  m_tdata,
    input  wire [2:0]   m_tuser,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire         m_tlast,
    input  wire         cfg_valid,
    input  wire         cfg_ready,
    input  wire         cfg_data,
    output int          mismatches,
    output int          awaited,
    output int          results_seen,
    output int          neighbor_fills
);

    localparam int REACH = SEARCH_REACH_DEF;
    localparam int VB    = VALUE_BITS_DEF;

    typedef struct {
        logic [VB-2:0] value;
        logic [1:0]    code;
        logic          missing;
        logic          last;
    } filled_point_t;

    // Mirror of the block: filled row history, held points and the enable register
    logic signed [VB-1:0] left_hist [REACH];
    int                   left_cnt;
    logic signed [VB-1:0] held_today [REACH+1];
    logic signed [VB-1:0] held_prev [REACH+1];
    int                   held_cnt;
    logic                 fill_en;
    filled_point_t        expected_fills [$];

    // Report the first few mismatches, count all of them
    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, what);
    endtask

    // Fill the oldest held point and queue its expected result
    function automatic void release_oldest(input bit last);
        logic signed [VB-1:0] t;
        logic signed [VB-1:0] p;
        logic signed [VB-1:0] v;
        logic [1:0]           code;
        logic                 miss;
        bit                   found;
        int                   k;
        filled_point_t        r;
        t = held_today[0];
        p = held_prev[0];
        v = t;
        code = CODE_ORIGINAL;
        miss = 1'b0;
        found = 1'b0;
        if (fill_en && t == 0) begin
            miss = 1'b1;
            if (p != 0) begin
                v = p;
                code = CODE_PREVIOUS;
            end else begin
                // per distance: left among filled values first, then right among originals
                for (k = 1; k <= REACH && !found; k++) begin
                    if (k <= left_cnt && left_hist[k-1] > 0) begin
                        v = left_hist[k-1];
                        found = 1'b1;
                    end else if (k < held_cnt && held_today[k] > 0) begin
                        v = held_today[k];
                        found = 1'b1;
                    end
                end
                if (found)
                    code = CODE_NEIGHBOR;
            end
        end
        for (k = REACH - 1; k > 0; k--)
            left_hist[k] = left_hist[k-1];
        left_hist[0] = v;
        if (left_cnt < REACH)
            left_cnt++;
        for (k = 0; k < REACH; k++) begin
            held_today[k] = held_today[k+1];
            held_prev[k] = held_prev[k+1];
        end
        held_cnt--;
        r.value = (v > 0) ? v[VB-2:0] : '0;
        r.code = code;
        r.missing = miss;
        r.last = last;
        expected_fills.push_back(r);
    endfunction

    // Accept one grid point: hold it, release what it pushes out or what its row end drains
    function automatic void take_point(input logic signed [VB-1:0] t,
                                       input logic signed [VB-1:0] p, input bit row_end);
        int n;
        int k;
        n = 0;
        if (held_cnt > REACH) begin
            release_oldest(1'b0);
            n = 1;
        end
        held_today[held_cnt] = t;
        held_prev[held_cnt] = p;
        held_cnt++;
        if (row_end) begin
            while (held_cnt > 0)
                release_oldest(held_cnt == 1);
            for (k = 0; k < REACH; k++)
                left_hist[k] = '0;
            left_cnt = 0;
        end else if (held_cnt > REACH && n == 0) begin
            release_oldest(1'b0);
        end
    endfunction

    // Watch the three channels at each rising edge
    always @(posedge aclk) begin
        filled_point_t want;
        logic [15:0]   got_value;
        if (!aresetn) begin
            for (int k = 0; k < REACH; k++)
                left_hist[k] = '0;
            for (int k = 0; k <= REACH; k++) begin
                held_today[k] = '0;
                held_prev[k] = '0;
            end
            left_cnt = 0;
            held_cnt = 0;
            fill_en = 1'b1;
            expected_fills.delete();
        end else begin
            // compare a result first: it cannot stem from an item taken at this edge
            if (m_tvalid && m_tready) begin
                results_seen++;
                got_value = m_tdata;
                if (expected_fills.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result value %0d code %0d missing %0d last %0d",
                        got_value, m_tuser[1:0], m_tuser[2], m_tlast));
                end else begin
                    want = expected_fills.pop_front();
                    if (want.code == CODE_NEIGHBOR)
                        neighbor_fills++;
                    if (got_value != {1'b0, want.value} || m_tuser[1:0] !== want.code ||
                        m_tuser[2] !== want.missing || m_tlast !== want.last)
                        flag_mismatch($sformatf({"result mismatch: expected value %0d code %0d ",
                            "missing %0d last %0d, got value %0d code %0d missing %0d last %0d"},
                            want.value, want.code, want.missing, want.last,
                            got_value, m_tuser[1:0], m_tuser[2], m_tlast));
                end
            end
            if (cfg_valid && cfg_ready)
                fill_en = cfg_data;
            if (s_tvalid && s_tready)
                take_point(s_tdata[VB-1:0], s_tdata[2*VB-1:VB], s_tlast);
        end
        awaited = expected_fills.size();
    end

endmodule

// ----- verif/grid_row_gap_filler_unit_tb.sv -----
// Testbench top for the grid row gap filler: clock, reset, stimulus and verdict.
module grid_row_gap_filler_unit_tb;

    localparam logic [4:0] SEG_FILL = 5'b01101;
    localparam int SEG_ITEMS = 37;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic [31:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic        s_tlast;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    int mismatches;
    int awaited;
    int results_seen;
    int neighbor_fills;
    int send_pct;
    int stall_pct;
    int points_sent;
    int rows_sent;

    grid_row_gap_filler_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    gap_fill_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tlast       (s_tlast),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .awaited       (awaited),
        .results_seen  (results_seen),
        .neighbor_fills(neighbor_fills)
    );

    always #4 aclk = ~aclk;

    // Stall the result channel at random
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Hard stop if the run hangs
    initial begin
        #2000000;
        $display("grid_row_gap_filler_unit_tb NOT OK");
        $finish;
    end

    // Offer one grid point, idling first at random, and hold it until taken
    task automatic send_point(input logic [15:0] today, input logic [15:0] prev,
                              input bit row_end);
        @(negedge aclk);
        while (send_pct > 0 && $urandom_range(99) < send_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {prev, today};
        s_tlast <= row_end;
        do @(posedge aclk); while (!s_tready);
        points_sent++;
        if (row_end)
            rows_sent++;
    endtask

    // Drop valid and wait until every expected result has come and the block settles
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (awaited == 0);
        repeat (16) @(posedge aclk);
    endtask

    // Write fill_enable on the config channel
    task automatic write_fill_enable(input logic en);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= en;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int seg;
        int seg_items;
        int len;
        int style;
        int i;
        logic [15:0] t;
        logic [15:0] p;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        send_pct = 0;
        stall_pct = 0;
        points_sent = 0;
        rows_sent = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed rows with fill on
        write_fill_enable(1'b1);
        send_point(16'sd32767, 16'sd0, 1'b0);      // original at top of range
        send_point(16'sd0, -16'sd32768, 1'b0);    // negative previous day value
        send_point(16'sd0, 16'sd0, 1'b0);         // left skips negative, finds 32767
        send_point(-16'sd1, 16'sd32767, 1'b0);    // negative original
        send_point(16'sd0, 16'sd32767, 1'b0);     // previous day fill
        send_point(16'sd0, 16'sd0, 1'b0);         // nearest left neighbor
        send_point(-16'sd32768, -16'sd1, 1'b1);
        send_point(16'sd0, 16'sd0, 1'b0);         // row start: only right side
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd1, 16'sd0, 1'b1);
        send_point(16'sd0, 16'sd0, 1'b1);         // lone point, nothing to fill from
        send_point(16'sd0, 16'sd1, 1'b1);
        send_point(16'sd0, 16'sd0, 1'b0);         // whole row without positive value
        send_point(-16'sd5, 16'sd0, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b1);
        send_point(16'h5555, 16'hAAAA, 1'b0);
        send_point(16'h2AAA, 16'h5555, 1'b1);
        // Same kind of points with fill off
        drain_results();
        write_fill_enable(1'b0);
        send_point(16'sd0, 16'sd5, 1'b0);
        send_point(-16'sd3, 16'sd0, 1'b0);
        send_point(16'sd100, 16'sd0, 1'b1);

        // Random rows under each idle mix and both fill settings
        for (seg = 0; seg < 5; seg++) begin
            drain_results();
            case (seg)
                1: begin
                    send_pct = 55;
                    stall_pct = 0;
                end
                2: begin
                    send_pct = 0;
                    stall_pct = 55;
                end
                3: begin
                    send_pct = 9;
                    stall_pct = 9;
                end
                default: begin
                    send_pct = 0;
                    stall_pct = 0;
                end
            endcase
            write_fill_enable(SEG_FILL[seg]);
            seg_items = 0;
            while (seg_items < SEG_ITEMS) begin
                // mostly short rows, some longer than the search reach
                len = ($urandom_range(4) == 0) ? $urandom_range(45, 75) : $urandom_range(1, 20);
                style = $urandom_range(3);
                for (i = 0; i < len; i++) begin
                    case (style)
                        0, 1: begin
                            t = ($urandom_range(9) < 6) ? 16'd0 : 16'($urandom_range(65535));
                            p = ($urandom_range(9) < 7) ? 16'd0 : 16'($urandom_range(65535));
                        end
                        2: begin
                            // sparse row: long searches across the window
                            t = ($urandom_range(99) < 95) ? 16'd0 : 16'($urandom_range(1, 32767));
                            p = ($urandom_range(99) < 97) ? 16'd0 : 16'($urandom_range(65535));
                        end
                        default: begin
                            t = 16'($urandom_range(65535));
                            p = 16'($urandom_range(65535));
                        end
                    endcase
                    send_point(t, p, i == len - 1);
                    seg_items++;
                    // hold off mid row until every result is out
                    if (seg == 2 && seg_items == 30)
                        drain_results();
                end
            end
        end

        // Let the last results arrive
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (awaited == 0);
        repeat (40) @(posedge aclk);
        $display("Sent %0d grid points in %0d rows; checked %0d results, %0d neighbor fills,",
                 points_sent, rows_sent, results_seen, neighbor_fills);
        $display("with fill on and off under no idling, sender gaps, receiver stalls and both.");
        if (mismatches == 0 && awaited == 0) begin
            $display("grid_row_gap_filler_unit_tb OK");
        end else begin
            $display("grid_row_gap_filler_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/grgf_pkg.sv
design/grgf_cell.sv
design/grgf_ctrl.sv
design/grid_row_gap_filler_unit.sv
design/grgf_checker.sv
verif/gap_fill_checker.sv
verif/grid_row_gap_filler_unit_tb.sv
